// ===== rtl/typed_structure_table_walker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the structure table walker
// Same-cycle and next-cycle implication checks, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TYPED_STRUCTURE_TABLE_WALKER_CORE_ASSERT_SVH
`define TYPED_STRUCTURE_TABLE_WALKER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TWK_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("walker assertion failed");

// antecedent implies consequent in the following cycle
`define TWK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("walker assertion failed");

`endif

// ===== rtl/twk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twk_pkg
// Types, codes and helpers shared by the structure table walker modules.
// ----------------------------------------------------------------------------
package twk_pkg;

    localparam logic [7:0] END_TYPE     = 8'd127;
    localparam logic [7:0] MIN_LEN      = 8'd4;
    localparam logic [7:0] HANDLE_START = 8'd4;
    localparam int         FIFO_DEPTH   = 4;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_FMT,
        PH_STR,
        PH_LEAD0
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FMT,
        KIND_STR_CHAR,
        KIND_STR_END,
        KIND_STRUCT_END,
        KIND_TABLE_DONE,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SHORT_LEN,
        ERR_TRUNCATED
    } err_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        kind_t       byte_kind;
        logic [7:0]  byte_offset;
        logic [7:0]  string_number;
        logic [15:0] structure_handle;
        err_t        error_code;
    } result_t;

    // results produced by one accepted byte, r0 first
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    function automatic result_t mk_res(input logic [7:0] b, input kind_t k,
                                       input logic [7:0] off, input logic [7:0] sn,
                                       input logic [15:0] h, input err_t e);
        result_t r;
        r.out_byte         = b;
        r.byte_kind        = k;
        r.byte_offset      = off;
        r.string_number    = sn;
        r.structure_handle = h;
        r.error_code       = e;
        mk_res = r;
    endfunction

endpackage

// ===== rtl/twk_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twk_parser
// Walk state and per-byte result generation; up to two results per byte.
// ----------------------------------------------------------------------------
`include "typed_structure_table_walker_core_assert.svh"

module twk_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_eob,
    input  logic [7:0]       wanted_type,
    output twk_pkg::push_t   push
);

    twk_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  fmt_len_reg, fmt_len_next;
    logic        match_reg, match_next;
    logic [15:0] handle_reg, handle_next;
    logic [7:0]  str_cnt_reg, str_cnt_next;
    logic [7:0]  char_cnt_reg, char_cnt_next;
    logic        stopped_reg, stopped_next;

    logic        type_hit;
    logic        end_hit;
    logic        off_one;
    logic        short_len;
    logic [7:0]  len_eff;
    logic [8:0]  off_plus;
    logic        halt;
    logic        struct_done;

    assign type_hit  = (in_byte == wanted_type);
    assign end_hit   = !type_hit && (in_byte == twk_pkg::END_TYPE);
    assign off_one   = (byte_cnt_reg == 8'd1);
    assign short_len = (in_byte < twk_pkg::MIN_LEN);
    assign len_eff   = off_one ? in_byte : fmt_len_reg;
    assign off_plus  = {1'b0, byte_cnt_reg} + 9'd1;

    // next walk state
    always_comb begin
        phase_next    = phase_reg;
        byte_cnt_next = byte_cnt_reg;
        fmt_len_next  = fmt_len_reg;
        match_next    = match_reg;
        handle_next   = handle_reg;
        str_cnt_next  = str_cnt_reg;
        char_cnt_next = char_cnt_reg;
        stopped_next  = stopped_reg;
        if (accept) begin
            if (!stopped_reg) begin
                case (phase_reg)
                    twk_pkg::PH_HEAD: begin
                        match_next = type_hit;
                        if (end_hit) begin
                            stopped_next = 1'b1;
                        end else begin
                            handle_next   = '0;
                            str_cnt_next  = '0;
                            char_cnt_next = '0;
                            fmt_len_next  = '0;
                            byte_cnt_next = 8'd1;
                            phase_next    = twk_pkg::PH_FMT;
                        end
                    end
                    twk_pkg::PH_FMT: begin
                        if (off_one) begin
                            fmt_len_next = in_byte;
                        end
                        if (off_one && short_len) begin
                            stopped_next = 1'b1;
                        end else begin
                            if (byte_cnt_reg == 8'd2) begin
                                handle_next = {handle_reg[15:8], in_byte};
                            end else if (byte_cnt_reg == 8'd3) begin
                                handle_next = {in_byte, handle_reg[7:0]};
                            end
                            if (off_plus >= {1'b0, len_eff}) begin
                                phase_next    = twk_pkg::PH_STR;
                                char_cnt_next = '0;
                            end else begin
                                byte_cnt_next = off_plus[7:0];
                            end
                        end
                    end
                    twk_pkg::PH_STR, twk_pkg::PH_LEAD0: begin
                        if (in_byte != 8'd0) begin
                            char_cnt_next = twk_pkg::sat_inc(char_cnt_reg);
                            phase_next    = twk_pkg::PH_STR;
                        end else if (char_cnt_reg != 8'd0) begin
                            str_cnt_next  = twk_pkg::sat_inc(str_cnt_reg);
                            char_cnt_next = '0;
                        end else if (phase_reg == twk_pkg::PH_STR && str_cnt_reg == 8'd0) begin
                            phase_next = twk_pkg::PH_LEAD0;
                        end else begin
                            phase_next    = twk_pkg::PH_HEAD;
                            byte_cnt_next = '0;
                        end
                    end
                    default: begin
                        phase_next = twk_pkg::PH_HEAD;
                    end
                endcase
            end
            // rearm for a new table after the last buffer byte
            if (in_eob) begin
                phase_next    = twk_pkg::PH_HEAD;
                byte_cnt_next = '0;
                fmt_len_next  = '0;
                match_next    = 1'b0;
                handle_next   = '0;
                str_cnt_next  = '0;
                char_cnt_next = '0;
                stopped_next  = 1'b0;
            end
        end
    end

    // results of the accepted byte
    always_comb begin
        push        = '0;
        halt        = 1'b0;
        struct_done = 1'b0;
        if (accept && !stopped_reg) begin
            case (phase_reg)
                twk_pkg::PH_HEAD: begin
                    if (end_hit) begin
                        halt     = 1'b1;
                        push.cnt = 2'd1;
                        push.r0  = twk_pkg::mk_res('0, twk_pkg::KIND_TABLE_DONE, '0, '0,
                                                   '0, twk_pkg::ERR_NONE);
                    end else if (type_hit) begin
                        push.cnt = 2'd1;
                        push.r0  = twk_pkg::mk_res(in_byte, twk_pkg::KIND_FMT, '0, '0,
                                                   '0, twk_pkg::ERR_NONE);
                    end
                end
                twk_pkg::PH_FMT: begin
                    if (off_one && short_len) begin
                        halt     = 1'b1;
                        push.cnt = 2'd2;
                        push.r0  = twk_pkg::mk_res('0, twk_pkg::KIND_ERROR, '0, '0,
                                                   '0, twk_pkg::ERR_SHORT_LEN);
                        push.r1  = twk_pkg::mk_res('0, twk_pkg::KIND_TABLE_DONE, '0, '0,
                                                   '0, twk_pkg::ERR_NONE);
                    end else if (match_reg) begin
                        push.cnt = 2'd1;
                        push.r0  = twk_pkg::mk_res(in_byte, twk_pkg::KIND_FMT, byte_cnt_reg,
                                   '0, (byte_cnt_reg >= twk_pkg::HANDLE_START) ? handle_reg
                                   : 16'd0, twk_pkg::ERR_NONE);
                    end
                end
                twk_pkg::PH_STR, twk_pkg::PH_LEAD0: begin
                    if (in_byte != 8'd0) begin
                        if (match_reg) begin
                            push.cnt = 2'd1;
                            push.r0  = twk_pkg::mk_res(in_byte, twk_pkg::KIND_STR_CHAR,
                                       char_cnt_reg, twk_pkg::sat_inc(str_cnt_reg),
                                       handle_reg, twk_pkg::ERR_NONE);
                        end
                    end else if (char_cnt_reg != 8'd0) begin
                        if (match_reg) begin
                            push.cnt = 2'd1;
                            push.r0  = twk_pkg::mk_res('0, twk_pkg::KIND_STR_END,
                                       char_cnt_reg, twk_pkg::sat_inc(str_cnt_reg),
                                       handle_reg, twk_pkg::ERR_NONE);
                        end
                    end else if (phase_reg == twk_pkg::PH_STR && str_cnt_reg == 8'd0) begin
                        // leading zero: wait for the second one
                        push.cnt = 2'd0;
                    end else begin
                        struct_done = 1'b1;
                        if (match_reg) begin
                            push.cnt = 2'd1;
                            push.r0  = twk_pkg::mk_res('0, twk_pkg::KIND_STRUCT_END, '0,
                                       str_cnt_reg, handle_reg, twk_pkg::ERR_NONE);
                        end
                    end
                end
                default: begin
                    push.cnt = 2'd0;
                end
            endcase
            if (in_eob && !halt) begin
                if (struct_done) begin
                    // append table done behind the structure end
                    if (push.cnt == 2'd0) begin
                        push.cnt = 2'd1;
                        push.r0  = twk_pkg::mk_res('0, twk_pkg::KIND_TABLE_DONE, '0, '0,
                                                   '0, twk_pkg::ERR_NONE);
                    end else begin
                        push.cnt = 2'd2;
                        push.r1  = twk_pkg::mk_res('0, twk_pkg::KIND_TABLE_DONE, '0, '0,
                                                   '0, twk_pkg::ERR_NONE);
                    end
                end else begin
                    // truncated: drop the byte's own result
                    push.cnt = 2'd2;
                    push.r0  = twk_pkg::mk_res('0, twk_pkg::KIND_ERROR, '0, '0,
                                               '0, twk_pkg::ERR_TRUNCATED);
                    push.r1  = twk_pkg::mk_res('0, twk_pkg::KIND_TABLE_DONE, '0, '0,
                                               '0, twk_pkg::ERR_NONE);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= twk_pkg::PH_HEAD;
            byte_cnt_reg <= '0;
            fmt_len_reg  <= '0;
            match_reg    <= 1'b0;
            handle_reg   <= '0;
            str_cnt_reg  <= '0;
            char_cnt_reg <= '0;
            stopped_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            byte_cnt_reg <= byte_cnt_next;
            fmt_len_reg  <= fmt_len_next;
            match_reg    <= match_next;
            handle_reg   <= handle_next;
            str_cnt_reg  <= str_cnt_next;
            char_cnt_reg <= char_cnt_next;
            stopped_reg  <= stopped_next;
        end
    end

    `TWK_ASSERT_IMPL(a_stopped_silent, aclk, aresetn, stopped_reg, push.cnt == 2'd0)
    `TWK_ASSERT_IMPL(a_second_is_done, aclk, aresetn, push.cnt == 2'd2, push.r1.byte_kind == twk_pkg::KIND_TABLE_DONE)
    `TWK_ASSERT_IMPL(a_lead0_empty, aclk, aresetn, phase_reg == twk_pkg::PH_LEAD0, str_cnt_reg == 8'd0 && char_cnt_reg == 8'd0)

endmodule

// ===== rtl/twk_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twk_result_fifo
// Result queue taking up to two results per cycle and giving one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "typed_structure_table_walker_core_assert.svh"

module twk_result_fifo #(
    parameter int DEPTH = twk_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  twk_pkg::push_t   push,
    output logic             space_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output twk_pkg::result_t out_res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twk_pkg::result_t mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] wr_ptr_p1, wr_ptr_p2, rd_ptr_p1;
    logic             pop;

    assign wr_ptr_p1 = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_ptr_p2 = (wr_ptr_p1 == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_p1 + 1'b1;
    assign rd_ptr_p1 = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = mem_reg[rd_ptr_reg];
    // room for the worst case of two results
    assign space_ok  = (cnt_reg <= CNT_W'(DEPTH - 2));

    always_comb begin
        cnt_next    = cnt_reg + CNT_W'(push.cnt) - CNT_W'(pop);
        rd_ptr_next = pop ? rd_ptr_p1 : rd_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = wr_ptr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `TWK_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push.cnt != 2'd0, ({1'b0, cnt_reg} + (CNT_W + 1)'(push.cnt)) <= (CNT_W + 1)'(DEPTH))
    `TWK_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `TWK_ASSERT_NEXT(a_push_shows, aclk, aresetn, push.cnt != 2'd0, out_valid)

endmodule

// ===== rtl/typed_structure_table_walker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_structure_table_walker_core
// Walks a typed structure table byte by byte and streams out the bytes of
// structures of the configured type, tagged by kind, offset, string, handle.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata: data_byte; tlast: end_of_buffer
//  m_*       out        tdata: out_byte .. error_code; tuser: byte_kind
//  cfg_*     in         wanted_type
//
// One byte is accepted per cycle while the result queue has two free slots;
// its results are offered from the cycle after the byte is accepted.
// A byte giving two results takes two queue slots, so s_tready drops when
// m_tready stays low or when such bytes arrive faster than the queue
// (FIFO_DEPTH entries) drains at one result per cycle.
// Reset is synchronous; wanted_type resets to 0.
// Results leave in the order the bytes arrived.
// ----------------------------------------------------------------------------
module typed_structure_table_walker_core #(
    parameter int FIFO_DEPTH = twk_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_byte, byte_offset, string_number,
                                   // structure_handle, error_code, zero pad
    output logic [2:0]  m_tuser,   // [2:0] byte_kind
    output logic        m_tlast
);

    logic [7:0]       wanted_type_reg;
    logic             accept;
    twk_pkg::push_t   push;
    twk_pkg::result_t head;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_type_reg <= '0;
        end else if (cfg_wr_en) begin
            wanted_type_reg <= cfg_wr_data;
        end
    end

    twk_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_tdata),
        .in_eob      (s_tlast),
        .wanted_type (wanted_type_reg),
        .push        (push)
    );

    twk_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata = {6'd0, head.error_code, head.structure_handle, head.string_number,
                      head.byte_offset, head.out_byte};
    assign m_tuser = head.byte_kind;
    // mark the end of each table on the result side
    assign m_tlast = (head.byte_kind == twk_pkg::KIND_TABLE_DONE);

endmodule

// ===== dv/typed_structure_table_walker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_structure_table_walker_core_tb
// Streams structure tables into the walker and checks each result against a
// local model of the walk: formatted bytes, strings, structure and table ends,
// short-length and truncation errors, stopped walks and saturated counters.
// Runs several wanted-type settings under varied source and sink idling.
// ----------------------------------------------------------------------------
module typed_structure_table_walker_core_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_PHASES    = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } table_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;   // [7:0] data_byte
    logic        s_tlast     = 1'b0;   // end_of_buffer
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;              // out_byte, byte_offset, string_number,
                                       // structure_handle, error_code
    logic [2:0]  m_tuser;              // [2:0] byte_kind
    logic        m_tlast;

    typed_structure_table_walker_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_HALF) aclk = ~aclk;

    table_byte_t      byte_queue[$];
    logic [7:0]       tbl_bytes[$];
    twk_pkg::result_t expected_results[$];
    int               mismatches    = 0;
    int               items_queued  = 0;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int               hold_asked    = 0;
    int               hold_served   = 0;
    int               hold_left     = 0;
    int               cycle_count   = 0;

    // walk state mirrored on the testbench side
    logic [7:0]       wanted_copy  = 8'd0;
    twk_pkg::phase_t  walk_phase   = twk_pkg::PH_HEAD;
    logic [7:0]       fmt_pos      = 8'd0;
    logic [7:0]       fmt_len      = 8'd0;
    logic [7:0]       strings_done = 8'd0;
    logic [7:0]       char_pos     = 8'd0;
    logic [15:0]      cur_handle   = 16'd0;
    logic             is_wanted    = 1'b0;
    logic             halted       = 1'b0;

    function automatic logic [7:0] sat8(input logic [7:0] v);
        sat8 = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    function automatic twk_pkg::result_t tag_result(input logic [7:0] b,
                                                    input twk_pkg::kind_t k,
                                                    input logic [7:0] off,
                                                    input logic [7:0] sn,
                                                    input logic [15:0] h,
                                                    input twk_pkg::err_t e);
        twk_pkg::result_t r;
        r.out_byte         = b;
        r.byte_kind        = k;
        r.byte_offset      = off;
        r.string_number    = sn;
        r.structure_handle = h;
        r.error_code       = e;
        tag_result = r;
    endfunction

    task automatic rearm_walk();
        walk_phase   = twk_pkg::PH_HEAD;
        fmt_pos      = 8'd0;
        fmt_len      = 8'd0;
        strings_done = 8'd0;
        char_pos     = 8'd0;
        cur_handle   = 16'd0;
        is_wanted    = 1'b0;
        halted       = 1'b0;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic eob);
        twk_pkg::result_t outs[$];
        twk_pkg::result_t table_done;
        logic [7:0]       off;
        logic             stop;
        logic             closed;
        stop       = 1'b0;
        closed     = 1'b0;
        off        = fmt_pos;
        table_done = tag_result(8'd0, twk_pkg::KIND_TABLE_DONE, 8'd0, 8'd0, 16'd0,
                                twk_pkg::ERR_NONE);
        if (halted) begin
            if (eob) rearm_walk();
        end else begin
            case (walk_phase)
                twk_pkg::PH_HEAD: begin
                    is_wanted = (b == wanted_copy);
                    if (!is_wanted && b == twk_pkg::END_TYPE) begin
                        outs.push_back(table_done);
                        stop = 1'b1;
                    end else begin
                        cur_handle   = 16'd0;
                        strings_done = 8'd0;
                        char_pos     = 8'd0;
                        fmt_len      = 8'd0;
                        if (is_wanted)
                            outs.push_back(tag_result(b, twk_pkg::KIND_FMT, 8'd0, 8'd0,
                                                      16'd0, twk_pkg::ERR_NONE));
                        fmt_pos    = 8'd1;
                        walk_phase = twk_pkg::PH_FMT;
                    end
                end
                twk_pkg::PH_FMT: begin
                    if (off == 8'd1 && b < twk_pkg::MIN_LEN) begin
                        fmt_len = b;
                        outs.push_back(tag_result(8'd0, twk_pkg::KIND_ERROR, 8'd0, 8'd0,
                                                  16'd0, twk_pkg::ERR_SHORT_LEN));
                        outs.push_back(table_done);
                        stop = 1'b1;
                    end else begin
                        if (off == 8'd1)
                            fmt_len = b;
                        else if (off == 8'd2)
                            cur_handle[7:0] = b;
                        else if (off == 8'd3)
                            cur_handle[15:8] = b;
                        if (is_wanted)
                            outs.push_back(tag_result(b, twk_pkg::KIND_FMT, off, 8'd0,
                                               (off >= twk_pkg::HANDLE_START) ? cur_handle
                                                                              : 16'd0,
                                               twk_pkg::ERR_NONE));
                        if ({1'b0, off} + 9'd1 >= {1'b0, fmt_len}) begin
                            walk_phase = twk_pkg::PH_STR;
                            char_pos   = 8'd0;
                        end else begin
                            fmt_pos = off + 8'd1;
                        end
                    end
                end
                default: begin
                    if (b != 8'd0) begin
                        if (is_wanted)
                            outs.push_back(tag_result(b, twk_pkg::KIND_STR_CHAR, char_pos,
                                                      sat8(strings_done), cur_handle,
                                                      twk_pkg::ERR_NONE));
                        char_pos   = sat8(char_pos);
                        walk_phase = twk_pkg::PH_STR;
                    end else if (char_pos != 8'd0) begin
                        strings_done = sat8(strings_done);
                        if (is_wanted)
                            outs.push_back(tag_result(8'd0, twk_pkg::KIND_STR_END, char_pos,
                                                      strings_done, cur_handle,
                                                      twk_pkg::ERR_NONE));
                        char_pos = 8'd0;
                    end else if (walk_phase == twk_pkg::PH_STR && strings_done == 8'd0) begin
                        // first zero of the string set: wait for a second one
                        walk_phase = twk_pkg::PH_LEAD0;
                    end else begin
                        if (is_wanted)
                            outs.push_back(tag_result(8'd0, twk_pkg::KIND_STRUCT_END, 8'd0,
                                                      strings_done, cur_handle,
                                                      twk_pkg::ERR_NONE));
                        closed = 1'b1;
                    end
                end
            endcase

            if (stop) begin
                halted = 1'b1;
                if (eob) rearm_walk();
            end else if (closed) begin
                walk_phase = twk_pkg::PH_HEAD;
                fmt_pos    = 8'd0;
                if (eob) begin
                    outs.push_back(table_done);
                    rearm_walk();
                end
            end else if (eob) begin
                // truncated mid-structure: drop the byte's own result
                outs.delete();
                outs.push_back(tag_result(8'd0, twk_pkg::KIND_ERROR, 8'd0, 8'd0, 16'd0,
                                          twk_pkg::ERR_TRUNCATED));
                outs.push_back(table_done);
                rearm_walk();
            end
        end
        foreach (outs[i]) expected_results.push_back(outs[i]);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_type();
        logic [7:0] t;
        int         r;
        r = $urandom_range(99);
        if (r < 45)
            t = wanted_copy;
        else if (r < 80)
            t = 8'($urandom_range(7));
        else
            t = 8'($urandom_range(255));
        // keep end-of-table markers for the table tail
        if (t == twk_pkg::END_TYPE && wanted_copy != twk_pkg::END_TYPE)
            t = 8'd126;
        pick_type = t;
    endfunction

    task automatic add_structure(input logic [7:0] typ);
        int len;
        int nstr;
        int clen;
        int r;
        r = $urandom_range(99);
        if (r < 80)
            len = $urandom_range(4, 12);
        else if (r < 95)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(4, 255);
        tbl_bytes.push_back(typ);
        tbl_bytes.push_back(8'(len));
        for (int i = 2; i < len; i++)
            tbl_bytes.push_back(8'($urandom_range(255)));
        nstr = $urandom_range(0, 3);
        if (nstr != 0 && $urandom_range(9) == 0)
            tbl_bytes.push_back(8'd0);
        for (int s = 0; s < nstr; s++) begin
            clen = $urandom_range(1, 6);
            repeat (clen) tbl_bytes.push_back(8'($urandom_range(1, 255)));
            tbl_bytes.push_back(8'd0);
        end
        if (nstr == 0)
            tbl_bytes.push_back(8'd0);
        tbl_bytes.push_back(8'd0);
    endtask

    // move the built table into the send queue, end of buffer on its last byte
    task automatic flush_table();
        table_byte_t tb;
        foreach (tbl_bytes[i]) begin
            tb.data = tbl_bytes[i];
            tb.last = (i == tbl_bytes.size() - 1);
            byte_queue.push_back(tb);
            items_queued++;
        end
        tbl_bytes.delete();
    endtask

    task automatic add_table();
        int nstruct;
        int ending;
        int start;
        int keep;
        nstruct = $urandom_range(1, 4);
        start   = 0;
        for (int k = 0; k < nstruct; k++) begin
            start = tbl_bytes.size();
            add_structure(pick_type());
        end
        ending = $urandom_range(99);
        if (ending < 45) begin
            // buffer ends on the last structure's closing zero
        end else if (ending < 70) begin
            tbl_bytes.push_back(twk_pkg::END_TYPE);
            repeat ($urandom_range(0, 5)) tbl_bytes.push_back(8'($urandom_range(255)));
        end else if (ending < 85) begin
            // cut the last structure short
            keep = $urandom_range(start + 1, tbl_bytes.size() - 1);
            while (tbl_bytes.size() > keep) tbl_bytes.delete(tbl_bytes.size() - 1);
        end else if (ending < 95) begin
            tbl_bytes.push_back(pick_type());
            tbl_bytes.push_back(8'($urandom_range(3)));
            repeat ($urandom_range(0, 3)) tbl_bytes.push_back(8'($urandom_range(255)));
        end else begin
            tbl_bytes.delete();
            repeat ($urandom_range(1, 8)) tbl_bytes.push_back(8'($urandom_range(255)));
        end
        flush_table();
    endtask

    task automatic write_wanted(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        wanted_copy = v;
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        table_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                walk_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink side: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : watch_results
        twk_pkg::result_t got;
        twk_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.out_byte         = m_tdata[7:0];
            got.byte_kind        = twk_pkg::kind_t'(m_tuser);
            got.byte_offset      = m_tdata[15:8];
            got.string_number    = m_tdata[23:16];
            got.structure_handle = m_tdata[39:24];
            got.error_code       = twk_pkg::err_t'(m_tdata[41:40]);
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                          got.byte_kind, got.out_byte));
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        {"got b=%02h k=%0d off=%0d sn=%0d h=%04h e=%0d, ",
                         "want b=%02h k=%0d off=%0d sn=%0d h=%04h e=%0d"},
                        got.out_byte, got.byte_kind, got.byte_offset, got.string_number,
                        got.structure_handle, got.error_code,
                        want.out_byte, want.byte_kind, want.byte_offset,
                        want.string_number, want.structure_handle, want.error_code));
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial begin
        int         target;
        logic [7:0] setting;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // wanted type still at its reset value of zero
        tbl_bytes = {8'h00, 8'h05, 8'hFF, 8'h80, 8'hAA, 8'h41, 8'h00, 8'h00,
                     8'h00, 8'h04, 8'h34, 8'h12, 8'h00, 8'hFF, 8'h00, 8'h00};
        flush_table();
        tbl_bytes = {twk_pkg::END_TYPE, 8'h00};
        flush_table();
        tbl_bytes = {8'h00, 8'h03, 8'h00};
        flush_table();
        tbl_bytes = {8'h00, 8'h04, 8'h01};
        flush_table();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0, 6:    setting = 8'hFF;
                1:       setting = twk_pkg::END_TYPE;
                3:       setting = 8'h00;
                5:       setting = 8'h01;
                default: setting = 8'($urandom_range(255));
            endcase
            write_wanted(setting);
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 59; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            // long sink hold-off while the source keeps offering
            if (p == 1 || p == 4)
                hold_asked = hold_asked + 1;
            @(negedge aclk);
            if (p == 0) begin
                // saturate the character offset and the string count
                tbl_bytes.push_back(wanted_copy);
                tbl_bytes.push_back(8'd4);
                tbl_bytes.push_back(8'h5A);
                tbl_bytes.push_back(8'hA5);
                repeat (300) tbl_bytes.push_back(8'($urandom_range(1, 255)));
                tbl_bytes.push_back(8'd0);
                repeat (258) begin
                    tbl_bytes.push_back(8'($urandom_range(1, 255)));
                    tbl_bytes.push_back(8'd0);
                end
                tbl_bytes.push_back(8'd0);
                flush_table();
            end
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) add_table();
            wait_idle();
        end

        if (mismatches == 0)
            $display("typed_structure_table_walker_core test passed");
        else
            $display("typed_structure_table_walker_core test failed");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("typed_structure_table_walker_core test failed");
        $finish;
    end

endmodule
